// ----- hw/rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the rotator position controller
// Event codes, status codes, drive codes, register indexes, item and result
// structs, and the feedback staleness check.
// ----------------------------------------------------------------------------
package arpc_pkg;

	// event codes carried by an input item
	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_SET      = 3'd1,
		OP_FEEDBACK = 3'd2,
		OP_STOP     = 3'd3,
		OP_ZERO     = 3'd4,
		OP_MAINT    = 3'd5,
		OP_FAULT    = 3'd6
	} opcode_t;

	// status codes reported with every result item
	typedef enum logic [3:0] {
		ERR_OK          = 4'd0,
		ERR_AZ_RANGE    = 4'd1,
		ERR_EL_RANGE    = 4'd2,
		ERR_FAULT       = 4'd3,
		ERR_NO_FEEDBACK = 4'd4,
		ERR_MAINT       = 4'd5,
		ERR_STALE       = 4'd6,
		ERR_RAW_RANGE   = 4'd7,
		ERR_MAPPED_EL   = 4'd8,
		ERR_ZERO        = 4'd9
	} err_t;

	// motor commands
	typedef enum logic [1:0] {
		DRV_STOP = 2'd0,
		DRV_POS  = 2'd1,
		DRV_NEG  = 2'd2
	} drive_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_EXT      = 2'd0,
		REG_TIMEOUT  = 2'd1,
		REG_DEADBAND = 2'd2
	} cfg_reg_t;

	localparam int CfgIndexW = 2;
	localparam int CfgDataW  = 16;

	// register reset values
	localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
	localparam logic [9:0]  DEADBAND_RESET = 10'd50;
	localparam logic [15:0] TIMEOUT_ZERO   = 16'd1000;
	localparam logic [15:0] MAINT_DEFAULT  = 16'd1000;

	// angle limits in centidegrees
	localparam logic signed [16:0] AZ_TGT_MAX = 17'sd35900;
	localparam logic signed [16:0] EL_TGT_MAX = 17'sd18000;
	localparam logic signed [16:0] RAW_AZ_END = 17'sd36000;
	localparam logic signed [16:0] RAW_EL_MAX = 17'sd18000;
	localparam logic signed [16:0] RAW_EL_MIN = -17'sd18000;
	localparam logic signed [17:0] MAP_EL_MAX = 18'sd18000;
	localparam logic signed [17:0] MAP_EL_MIN = -18'sd9000;
	localparam logic signed [17:0] TURN_18    = 18'sd36000;
	localparam logic signed [16:0] TURN_17    = 17'sd36000;
	localparam logic signed [16:0] HALF_POS   = 17'sd18000;
	localparam logic signed [16:0] HALF_NEG   = -17'sd18000;

	localparam logic [16:0] AGE_MAX = 17'h1FFFF;

	// one input item
	typedef struct packed {
		opcode_t            opcode;
		logic               az_valid;
		logic               el_valid;
		logic signed [16:0] az;
		logic signed [16:0] el;
		logic [15:0]        duration;
	} item_t;

	// one result item
	typedef struct packed {
		logic               accepted;
		err_t               error_code;
		drive_t             az_drive;
		drive_t             el_drive;
		logic               moving;
		logic               stale;
		logic               maint;
		logic               fault;
		logic [15:0]        pos_az;
		logic signed [15:0] pos_el;
	} result_t;

	// configuration write
	typedef struct packed {
		logic                 we;
		logic [CfgIndexW-1:0] idx;
		logic [CfgDataW-1:0]  data;
	} cfg_wr_t;

	// in external mode, seen feedback counts as stale once its age passes the timeout (zero means TIMEOUT_ZERO)
	function automatic logic stale_f(input logic ext, input logic seen,
			input logic [16:0] age, input logic [15:0] timeout);
		logic [15:0] limit;
		limit = (timeout == 16'd0) ? TIMEOUT_ZERO : timeout;
		return ext && seen && (age > {1'b0, limit});
	endfunction

endpackage

// ----- hw/rtl/antenna_rotator_position_controller.sv -----
// ----------------------------------------------------------------------------
// antenna_rotator_position_controller: two-axis rotator position controller
// Bang-bang drive with deadband, zero offsets, feedback timeout, maintenance
// window and fault latch, all in centidegrees.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in      | input     | in_valid / in_stall  | opcode, axis flags, angles,
//           |           |                      | duration_ms
//   out     | output    | out_valid / out_stall| status, drives, position
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One item per cycle while neither side stalls. The edge that takes an item
// loads the input register; the item's result is loaded into the result
// register when the item moves on, after a single pass through the event
// logic and the motion check that lie between those registers.
// Reset clears the valid flags and returns the state and configuration registers to their reset values.
// A stalled result holds in the output register while one more item waits
// in the input register; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module antenna_rotator_position_controller
	import arpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_write,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data,
	// input item
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           opcode,
	input  logic                 azimuth_valid,
	input  logic                 elevation_valid,
	input  logic signed [16:0]   azimuth_cdeg,
	input  logic signed [16:0]   elevation_cdeg,
	input  logic [15:0]          duration_ms,
	// result item
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 accepted,
	output logic [3:0]           error_code,
	output logic [1:0]           azimuth_drive,
	output logic [1:0]           elevation_drive,
	output logic                 moving,
	output logic                 feedback_expired,
	output logic                 maintenance_active,
	output logic                 driver_fault,
	output logic [15:0]          position_azimuth,
	output logic signed [15:0]   position_elevation
);

	item_t   item_in, item_s1;
	cfg_wr_t cfg;
	logic    valid_s1;
	logic    fire;
	result_t result, result_q;

	// gather the payload ports
	always_comb begin
		item_in.opcode   = opcode_t'(opcode);
		item_in.az_valid = azimuth_valid;
		item_in.el_valid = elevation_valid;
		item_in.az       = azimuth_cdeg;
		item_in.el       = elevation_cdeg;
		item_in.duration = duration_ms;
		cfg.we           = cfg_write;
		cfg.idx          = cfg_index;
		cfg.data         = cfg_data;
	end

	arpc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.item_in  (item_in),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	arpc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.fire    (fire),
		.item_s1 (item_s1),
		.result  (result)
	);

	arpc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.fire      (fire),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_q  (result_q)
	);

	// spread the result onto its ports
	assign accepted           = result_q.accepted;
	assign error_code         = result_q.error_code;
	assign azimuth_drive      = result_q.az_drive;
	assign elevation_drive    = result_q.el_drive;
	assign moving             = result_q.moving;
	assign feedback_expired   = result_q.stale;
	assign maintenance_active = result_q.maint;
	assign driver_fault       = result_q.fault;
	assign position_azimuth   = result_q.pos_az;
	assign position_elevation = result_q.pos_el;

endmodule

// ----- hw/rtl/arpc_in_stage.sv -----
// ----------------------------------------------------------------------------
// arpc_in_stage: input register
// Captures one item per cycle while not stalled and holds it until the core takes it.
// ----------------------------------------------------------------------------
module arpc_in_stage
	import arpc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t item_in,
	input  logic  fire,
	output logic  valid_s1,
	output item_t item_s1
);

	logic take;

	// stall only while a held item cannot move on
	assign in_stall = valid_s1 && !fire;
	assign take     = in_valid && !in_stall;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture the payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ----- hw/rtl/arpc_motion.sv -----
// ----------------------------------------------------------------------------
// arpc_motion: axis errors and deadband decision
// Wraps the azimuth error into a half turn and gives each axis its drive.
// ----------------------------------------------------------------------------
module arpc_motion
	import arpc_pkg::*;
(
	input  logic [15:0]        tgt_az,
	input  logic [14:0]        tgt_el,
	input  logic [15:0]        cur_az,
	input  logic signed [15:0] cur_el,
	input  logic [9:0]         deadband,
	output drive_t             az_dir,
	output drive_t             el_dir,
	output logic               outside
);

	logic signed [16:0] az_diff;
	logic signed [16:0] az_err;
	logic [16:0]        az_mag;
	logic signed [17:0] el_err;
	logic [17:0]        el_mag;
	logic               az_out;
	logic               el_out;

	// wrap the azimuth error into plus or minus half a turn
	assign az_diff = $signed({1'b0, tgt_az}) - $signed({1'b0, cur_az});

	always_comb begin
		if (az_diff > HALF_POS) begin
			az_err = az_diff - TURN_17;
		end else if (az_diff < HALF_NEG) begin
			az_err = az_diff + TURN_17;
		end else begin
			az_err = az_diff;
		end
	end

	assign el_err = $signed({3'b000, tgt_el}) - $signed({{2{cur_el[15]}}, cur_el});

	// take magnitudes and compare against the deadband
	assign az_mag = az_err[16] ? 17'(-az_err) : 17'(az_err);
	assign el_mag = el_err[17] ? 18'(-el_err) : 18'(el_err);
	assign az_out = az_mag > {7'd0, deadband};
	assign el_out = el_mag > {8'd0, deadband};

	assign az_dir  = !az_out ? DRV_STOP : (az_err[16] ? DRV_NEG : DRV_POS);
	assign el_dir  = !el_out ? DRV_STOP : (el_err[17] ? DRV_NEG : DRV_POS);
	assign outside = az_out || el_out;

endmodule

// ----- hw/rtl/arpc_core.sv -----
// ----------------------------------------------------------------------------
// arpc_core: controller state and event handling
// Holds configuration and axis state, applies one event per cycle while items fire and forms
// the status of the result item from the updated state.
// ----------------------------------------------------------------------------
module arpc_core
	import arpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    fire,
	input  item_t   item_s1,
	output result_t result
);

	// configuration
	logic        ext_q;
	logic [15:0] timeout_q;
	logic [9:0]  deadband_q;

	// axis and control state
	logic [15:0]        tgt_az_q, tgt_az_d;
	logic [14:0]        tgt_el_q, tgt_el_d;
	logic [15:0]        cur_az_q, cur_az_d;
	logic signed [15:0] cur_el_q, cur_el_d;
	logic [15:0]        zoff_az_q, zoff_az_d;
	logic signed [15:0] zoff_el_q, zoff_el_d;
	logic [15:0]        raw_az_q, raw_az_d;
	logic signed [15:0] raw_el_q, raw_el_d;
	logic               cmd_q, cmd_d;
	logic               moving_q, moving_d, moving_keep;
	logic               seen_q, seen_d;
	logic [16:0]        age_q, age_d;
	logic [15:0]        rem_q, rem_d;
	logic               maint_q, maint_d;
	logic               fault_q, fault_d;

	logic               accepted;
	err_t               err;
	logic               eval;
	logic               stale_old, stale_new;
	logic               raw_bad, el_map_bad;
	logic signed [17:0] fb_az_diff, fb_az_map;
	logic signed [17:0] fb_el_map;
	drive_t             az_dir, el_dir;
	logic               outside;
	logic               moving_eval;

	assign stale_old = stale_f(ext_q, seen_q, age_q, timeout_q);

	// map raw feedback through the zero offsets
	assign raw_bad = item_s1.az[16] || (item_s1.az >= RAW_AZ_END) ||
		(item_s1.el < RAW_EL_MIN) || (item_s1.el > RAW_EL_MAX);
	assign fb_az_diff = $signed({2'b00, item_s1.az[15:0]}) - $signed({2'b00, zoff_az_q});
	assign fb_az_map  = fb_az_diff[17] ? fb_az_diff + TURN_18 : fb_az_diff;
	assign fb_el_map  = $signed({item_s1.el[16], item_s1.el}) -
		$signed({{2{zoff_el_q[15]}}, zoff_el_q});
	assign el_map_bad = (fb_el_map < MAP_EL_MIN) || (fb_el_map > MAP_EL_MAX);

	// next state for the event held in the input register
	always_comb begin
		tgt_az_d    = tgt_az_q;
		tgt_el_d    = tgt_el_q;
		cur_az_d    = cur_az_q;
		cur_el_d    = cur_el_q;
		zoff_az_d   = zoff_az_q;
		zoff_el_d   = zoff_el_q;
		raw_az_d    = raw_az_q;
		raw_el_d    = raw_el_q;
		cmd_d       = cmd_q;
		moving_keep = moving_q;
		seen_d      = seen_q;
		age_d       = age_q;
		rem_d       = rem_q;
		maint_d     = maint_q;
		fault_d     = fault_q;
		accepted    = 1'b1;
		err         = ERR_OK;
		eval        = 1'b0;

		unique case (item_s1.opcode)
			OP_TICK: begin
				if (age_q != AGE_MAX) begin
					age_d = age_q + 17'd1;
				end
				if (maint_q) begin
					if (rem_q == 16'd0) begin
						maint_d = 1'b0;
					end else begin
						rem_d = rem_q - 16'd1;
					end
				end
				eval = 1'b1;
			end
			OP_SET: begin
				priority if (item_s1.az_valid &&
						(item_s1.az[16] || item_s1.az > AZ_TGT_MAX)) begin
					err = ERR_AZ_RANGE;
				end else if (item_s1.el_valid &&
						(item_s1.el[16] || item_s1.el > EL_TGT_MAX)) begin
					err = ERR_EL_RANGE;
				end else if (fault_q) begin
					err = ERR_FAULT;
				end else if (ext_q && !seen_q) begin
					err = ERR_NO_FEEDBACK;
				end else if (maint_q) begin
					err = ERR_MAINT;
				end else if (stale_old) begin
					err = ERR_STALE;
				end else begin
					err = ERR_OK;
				end
				if (err != ERR_OK) begin
					accepted = 1'b0;
				end else begin
					if (item_s1.az_valid) begin
						tgt_az_d = item_s1.az[15:0];
					end
					if (item_s1.el_valid) begin
						tgt_el_d = item_s1.el[14:0];
					end
					cmd_d = 1'b1;
					// simulator mode: the target is reached at once
					if (!ext_q) begin
						cur_az_d = tgt_az_d;
						cur_el_d = $signed({1'b0, tgt_el_d});
						cmd_d    = 1'b0;
					end
					eval = 1'b1;
				end
			end
			OP_FEEDBACK: begin
				if (raw_bad) begin
					accepted = 1'b0;
					err      = ERR_RAW_RANGE;
				end else if (el_map_bad) begin
					accepted = 1'b0;
					err      = ERR_MAPPED_EL;
				end else begin
					raw_az_d = item_s1.az[15:0];
					raw_el_d = item_s1.el[15:0];
					seen_d   = 1'b1;
					age_d    = 17'd0;
					maint_d  = 1'b0;
					rem_d    = 16'd0;
					cur_az_d = fb_az_map[15:0];
					cur_el_d = fb_el_map[15:0];
					eval     = 1'b1;
				end
			end
			OP_STOP: begin
				cmd_d       = 1'b0;
				moving_keep = 1'b0;
			end
			OP_ZERO: begin
				if (moving_q || (ext_q && !seen_q) || maint_q || stale_old) begin
					accepted = 1'b0;
					err      = ERR_ZERO;
				end else begin
					cmd_d = 1'b0;
					if (ext_q) begin
						zoff_az_d = raw_az_q;
						zoff_el_d = raw_el_q;
					end
					cur_az_d    = 16'd0;
					cur_el_d    = 16'sd0;
					moving_keep = 1'b0;
					tgt_az_d    = 16'd0;
					tgt_el_d    = 15'd0;
				end
			end
			OP_MAINT: begin
				rem_d       = (item_s1.duration == 16'd0) ? MAINT_DEFAULT : item_s1.duration;
				maint_d     = 1'b1;
				cmd_d       = 1'b0;
				moving_keep = 1'b0;
			end
			OP_FAULT: begin
				fault_d     = 1'b1;
				cmd_d       = 1'b0;
				moving_keep = 1'b0;
			end
			default: begin
				accepted = 1'b0;
			end
		endcase
	end

	// evaluate motion on the updated state
	arpc_motion u_motion (
		.tgt_az   (tgt_az_d),
		.tgt_el   (tgt_el_d),
		.cur_az   (cur_az_d),
		.cur_el   (cur_el_d),
		.deadband (deadband_q),
		.az_dir   (az_dir),
		.el_dir   (el_dir),
		.outside  (outside)
	);

	assign stale_new   = stale_f(ext_q, seen_d, age_d, timeout_q);
	assign moving_eval = ext_q && cmd_d && seen_d && !stale_new && !fault_d && outside;
	assign moving_d    = eval ? moving_eval : moving_keep;

	// form the status from the updated state
	always_comb begin
		result.accepted   = accepted;
		result.error_code = err;
		result.az_drive   = moving_d ? az_dir : DRV_STOP;
		result.el_drive   = moving_d ? el_dir : DRV_STOP;
		result.moving     = moving_d && !stale_new && !fault_d && !maint_d;
		result.stale      = stale_new;
		result.maint      = maint_d;
		result.fault      = fault_d;
		result.pos_az     = cur_az_d;
		result.pos_el     = cur_el_d;
	end

	// update state on each event and configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q      <= 1'b0;
			timeout_q  <= TIMEOUT_RESET;
			deadband_q <= DEADBAND_RESET;
			tgt_az_q   <= '0;
			tgt_el_q   <= '0;
			cur_az_q   <= '0;
			cur_el_q   <= '0;
			zoff_az_q  <= '0;
			zoff_el_q  <= '0;
			raw_az_q   <= '0;
			raw_el_q   <= '0;
			cmd_q      <= 1'b0;
			moving_q   <= 1'b0;
			seen_q     <= 1'b0;
			age_q      <= '0;
			rem_q      <= '0;
			maint_q    <= 1'b0;
			fault_q    <= 1'b0;
		end else begin
			if (fire) begin
				tgt_az_q  <= tgt_az_d;
				tgt_el_q  <= tgt_el_d;
				cur_az_q  <= cur_az_d;
				cur_el_q  <= cur_el_d;
				zoff_az_q <= zoff_az_d;
				zoff_el_q <= zoff_el_d;
				raw_az_q  <= raw_az_d;
				raw_el_q  <= raw_el_d;
				cmd_q     <= cmd_d;
				moving_q  <= moving_d;
				seen_q    <= seen_d;
				age_q     <= age_d;
				rem_q     <= rem_d;
				maint_q   <= maint_d;
				fault_q   <= fault_d;
			end
			if (cfg.we) begin
				unique case (cfg_reg_t'(cfg.idx))
					REG_EXT: begin
						ext_q <= cfg.data[0];
						// entering external mode drops motion and feedback
						if (cfg.data[0]) begin
							cmd_q    <= 1'b0;
							moving_q <= 1'b0;
							seen_q   <= 1'b0;
						end
					end
					REG_TIMEOUT: begin
						timeout_q <= cfg.data;
					end
					REG_DEADBAND: begin
						deadband_q <= cfg.data[9:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// ----- hw/rtl/arpc_out_stage.sv -----
// ----------------------------------------------------------------------------
// arpc_out_stage: result register
// Holds a result item until the receiver takes it.
// ----------------------------------------------------------------------------
module arpc_out_stage
	import arpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t result,
	output logic    fire,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t result_q
);

	// advance when the register is empty or being emptied
	assign fire = valid_s1 && (!out_valid || !out_stall);

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// load the result
	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result;
		end
	end

endmodule

// ----- tb/sv/tb_antenna_rotator_position_controller.sv -----
// ----------------------------------------------------------------------------
// tb_antenna_rotator_position_controller: self-checking bench of the rotator
// A status board class mirrors the controller: it updates its own copy of the
// targets, positions, offsets, feedback age, maintenance window and fault
// latch for every item the controller takes, and queues the status that item must give.
// Each result item is checked field by field against the oldest queued one.
// A directed opening is followed by random phases under several register
// settings, with idling on the input side, stalls on the output side, and
// neither.
// ----------------------------------------------------------------------------
module tb_antenna_rotator_position_controller;
	import arpc_pkg::*;

	localparam logic [2:0] OP_UNUSED  = 3'd7;
	localparam int         IDLE_LIMIT = 4000;

	// mirror of the controller with a queue of expected status items
	class rotator_status_board;
		bit                 ext_en;
		logic [15:0]        timeout_ms;
		logic [9:0]         deadband;
		logic [15:0]        tgt_az;
		logic signed [15:0] tgt_el;
		logic [15:0]        cur_az;
		logic signed [15:0] cur_el;
		logic [15:0]        off_az;
		logic signed [15:0] off_el;
		logic [15:0]        raw_az;
		logic signed [15:0] raw_el;
		bit                 commanded;
		bit                 move_flag;
		bit                 fb_seen;
		logic [16:0]        fb_age;
		logic [15:0]        maint_left;
		bit                 maint_on;
		bit                 fault_on;
		result_t            status_q[$];
		int                 fail_count;

		function new();
			ext_en     = 1'b0;
			timeout_ms = TIMEOUT_RESET;
			deadband   = DEADBAND_RESET;
			tgt_az     = '0;
			tgt_el     = '0;
			cur_az     = '0;
			cur_el     = '0;
			off_az     = '0;
			off_el     = '0;
			raw_az     = '0;
			raw_el     = '0;
			commanded  = 1'b0;
			move_flag  = 1'b0;
			fb_seen    = 1'b0;
			fb_age     = '0;
			maint_left = '0;
			maint_on   = 1'b0;
			fault_on   = 1'b0;
			fail_count = 0;
		endfunction

		// wrap the azimuth error into one half turn either way
		function int az_err();
			int e;
			e = int'(tgt_az) - int'(cur_az);
			while (e > 18000) e -= 36000;
			while (e < -18000) e += 36000;
			return e;
		endfunction

		function int el_err();
			return int'(tgt_el) - int'(cur_el);
		endfunction

		function bit out_of_band(int e);
			int m;
			m = (e < 0) ? -e : e;
			return m > int'(deadband);
		endfunction

		function drive_t drive_for(int e);
			if (!out_of_band(e))
				return DRV_STOP;
			return (e > 0) ? DRV_POS : DRV_NEG;
		endfunction

		function bit fb_stale();
			logic [15:0] lim;
			lim = (timeout_ms == 16'd0) ? TIMEOUT_ZERO : timeout_ms;
			return ext_en && fb_seen && (fb_age > {1'b0, lim});
		endfunction

		function void update_motion();
			move_flag = ext_en && commanded && fb_seen && !fb_stale() && !fault_on &&
				(out_of_band(az_err()) || out_of_band(el_err()));
		endfunction

		function void set_reg(cfg_reg_t idx, logic [15:0] val);
			case (idx)
				REG_EXT: begin
					ext_en = val[0];
					if (ext_en) begin
						commanded = 1'b0;
						move_flag = 1'b0;
						fb_seen   = 1'b0;
					end
				end
				REG_TIMEOUT:  timeout_ms = val;
				REG_DEADBAND: deadband = val[9:0];
				default: ;
			endcase
		endfunction

		// apply one taken item and queue the status it must produce
		function void take_event(item_t it);
			result_t r;
			int      a;
			int      e;
			int      maz;
			int      mel;
			bit      ok;
			bit      st;
			err_t    code;
			ok   = 1'b1;
			code = ERR_OK;
			a    = $signed(it.az);
			e    = $signed(it.el);
			case (it.opcode)
				OP_TICK: begin
					if (fb_age != AGE_MAX)
						fb_age = fb_age + 17'd1;
					if (maint_on) begin
						if (maint_left == 16'd0)
							maint_on = 1'b0;
						else
							maint_left = maint_left - 16'd1;
					end
					update_motion();
				end
				OP_SET: begin
					if (it.az_valid && (a < 0 || a > 35900))
						code = ERR_AZ_RANGE;
					else if (it.el_valid && (e < 0 || e > 18000))
						code = ERR_EL_RANGE;
					else if (fault_on)
						code = ERR_FAULT;
					else if (ext_en && !fb_seen)
						code = ERR_NO_FEEDBACK;
					else if (maint_on)
						code = ERR_MAINT;
					else if (fb_stale())
						code = ERR_STALE;
					if (code != ERR_OK) begin
						ok = 1'b0;
					end else begin
						if (it.az_valid)
							tgt_az = a[15:0];
						if (it.el_valid)
							tgt_el = e[15:0];
						commanded = 1'b1;
						// simulator mode lands on the target at once
						if (!ext_en) begin
							cur_az    = tgt_az;
							cur_el    = tgt_el;
							commanded = 1'b0;
						end
						update_motion();
					end
				end
				OP_FEEDBACK: begin
					if (a < 0 || a >= 36000 || e < -18000 || e > 18000) begin
						ok   = 1'b0;
						code = ERR_RAW_RANGE;
					end else begin
						maz = a - int'(off_az);
						while (maz >= 36000) maz -= 36000;
						while (maz < 0) maz += 36000;
						mel = e - int'(off_el);
						if (mel < -9000 || mel > 18000) begin
							ok   = 1'b0;
							code = ERR_MAPPED_EL;
						end else begin
							raw_az     = a[15:0];
							raw_el     = e[15:0];
							fb_seen    = 1'b1;
							fb_age     = '0;
							maint_on   = 1'b0;
							maint_left = '0;
							cur_az     = maz[15:0];
							cur_el     = mel[15:0];
							update_motion();
						end
					end
				end
				OP_STOP: begin
					commanded = 1'b0;
					move_flag = 1'b0;
				end
				OP_ZERO: begin
					if (move_flag || (ext_en && !fb_seen) || maint_on || fb_stale()) begin
						ok   = 1'b0;
						code = ERR_ZERO;
					end else begin
						commanded = 1'b0;
						if (ext_en) begin
							off_az = raw_az;
							off_el = raw_el;
						end
						cur_az    = '0;
						cur_el    = '0;
						move_flag = 1'b0;
						tgt_az    = '0;
						tgt_el    = '0;
					end
				end
				OP_MAINT: begin
					maint_left = (it.duration == 16'd0) ? MAINT_DEFAULT : it.duration;
					maint_on   = 1'b1;
					commanded  = 1'b0;
					move_flag  = 1'b0;
				end
				OP_FAULT: begin
					fault_on  = 1'b1;
					commanded = 1'b0;
					move_flag = 1'b0;
				end
				default: ok = 1'b0;
			endcase
			st           = fb_stale();
			r.accepted   = ok;
			r.error_code = code;
			r.az_drive   = move_flag ? drive_for(az_err()) : DRV_STOP;
			r.el_drive   = move_flag ? drive_for(el_err()) : DRV_STOP;
			r.moving     = move_flag && !st && !fault_on && !maint_on;
			r.stale      = st;
			r.maint      = maint_on;
			r.fault      = fault_on;
			r.pos_az     = cur_az;
			r.pos_el     = cur_el;
			status_q.push_back(r);
		endfunction

		function void compare_field(string what, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
				fail_count++;
			end
		endfunction

		// check one result item against the oldest expected status
		function void check_status(result_t got);
			result_t want;
			if (status_q.size() == 0) begin
				$display("%0t: result item with none expected, actual %h", $time, got);
				fail_count++;
				return;
			end
			want = status_q.pop_front();
			compare_field("accepted", want.accepted, got.accepted);
			compare_field("error_code", want.error_code, got.error_code);
			compare_field("azimuth_drive", want.az_drive, got.az_drive);
			compare_field("elevation_drive", want.el_drive, got.el_drive);
			compare_field("moving", want.moving, got.moving);
			compare_field("feedback_expired", want.stale, got.stale);
			compare_field("maintenance_active", want.maint, got.maint);
			compare_field("driver_fault", want.fault, got.fault);
			compare_field("position_azimuth", want.pos_az, got.pos_az);
			compare_field("position_elevation", $signed(want.pos_el), $signed(got.pos_el));
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n          = 1'b0;
	logic                 cfg_write       = 1'b0;
	logic [CfgIndexW-1:0] cfg_index       = '0;
	logic [CfgDataW-1:0]  cfg_data        = '0;
	logic                 in_valid        = 1'b0;
	logic                 in_stall;
	logic [2:0]           opcode          = '0;
	logic                 azimuth_valid   = 1'b0;
	logic                 elevation_valid = 1'b0;
	logic signed [16:0]   azimuth_cdeg    = '0;
	logic signed [16:0]   elevation_cdeg  = '0;
	logic [15:0]          duration_ms     = '0;
	logic                 out_valid;
	logic                 out_stall       = 1'b0;
	logic                 accepted;
	logic [3:0]           error_code;
	logic [1:0]           azimuth_drive;
	logic [1:0]           elevation_drive;
	logic                 moving;
	logic                 feedback_expired;
	logic                 maintenance_active;
	logic                 driver_fault;
	logic [15:0]          position_azimuth;
	logic signed [15:0]   position_elevation;

	rotator_status_board sb = new();
	int send_idle_pct  = 31;
	int recv_stall_pct = 70;
	int idle_cycles    = 0;

	antenna_rotator_position_controller u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.opcode             (opcode),
		.azimuth_valid      (azimuth_valid),
		.elevation_valid    (elevation_valid),
		.azimuth_cdeg       (azimuth_cdeg),
		.elevation_cdeg     (elevation_cdeg),
		.duration_ms        (duration_ms),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.accepted           (accepted),
		.error_code         (error_code),
		.azimuth_drive      (azimuth_drive),
		.elevation_drive    (elevation_drive),
		.moving             (moving),
		.feedback_expired   (feedback_expired),
		.maintenance_active (maintenance_active),
		.driver_fault       (driver_fault),
		.position_azimuth   (position_azimuth),
		.position_elevation (position_elevation)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// stall the result side at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// check result items mid-cycle, when all signals are settled
	always @(negedge clk) begin
		result_t act;
		if (arst_n && out_valid && !out_stall) begin
			act.accepted   = accepted;
			act.error_code = err_t'(error_code);
			act.az_drive   = drive_t'(azimuth_drive);
			act.el_drive   = drive_t'(elevation_drive);
			act.moving     = moving;
			act.stale      = feedback_expired;
			act.maint      = maintenance_active;
			act.fault      = driver_fault;
			act.pos_az     = position_azimuth;
			act.pos_el     = position_elevation;
			sb.check_status(act);
		end
	end

	// end the run when no item moves on either side for too long
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic item_t mk(opcode_t op, bit azv, bit elv, int az, int el, int dur);
		item_t it;
		it.opcode   = op;
		it.az_valid = azv;
		it.el_valid = elv;
		it.az       = 17'(az);
		it.el       = 17'(el);
		it.duration = 16'(dur);
		return it;
	endfunction

	function automatic int target_az();
		case ($urandom_range(9))
			0: return 0;
			1: return 35900;
			2: return 35901 + int'($urandom_range(200));
			3: return -int'($urandom_range(1, 65536));
			4: return $signed(17'($urandom));
			default: return int'($urandom_range(35900));
		endcase
	endfunction

	function automatic int target_el();
		case ($urandom_range(9))
			0: return 0;
			1: return 18000;
			2: return 18001 + int'($urandom_range(200));
			3: return -int'($urandom_range(1, 65536));
			4: return $signed(17'($urandom));
			default: return int'($urandom_range(18000));
		endcase
	endfunction

	// raw azimuth, often close to the raw value of the current target
	function automatic int sensor_az();
		int v;
		case ($urandom_range(11))
			0, 1, 2, 3: begin
				v = int'(sb.tgt_az) + int'(sb.off_az) + int'($urandom_range(240)) - 120;
				while (v >= 36000) v -= 36000;
				while (v < 0) v += 36000;
				return v;
			end
			4: return 0;
			5: return 35999;
			6: return 36000 + int'($urandom_range(100));
			7: return -int'($urandom_range(1, 65536));
			8: return $signed(17'($urandom));
			default: return int'($urandom_range(35999));
		endcase
	endfunction

	function automatic int sensor_el();
		case ($urandom_range(11))
			0, 1, 2, 3: return int'(sb.tgt_el) + int'(sb.off_el) +
				int'($urandom_range(240)) - 120;
			4: return -18000;
			5: return 18000;
			6: return 18001;
			7: return -18001;
			8: return $signed(17'($urandom));
			default: return int'($urandom_range(27000)) - 9000;
		endcase
	endfunction

	// random item; fields that the opcode ignores carry noise
	function automatic item_t random_item();
		item_t it;
		int    pick;
		it.opcode   = OP_TICK;
		it.az_valid = 1'($urandom_range(1));
		it.el_valid = 1'($urandom_range(1));
		it.az       = 17'($urandom);
		it.el       = 17'($urandom);
		it.duration = 16'($urandom);
		pick        = $urandom_range(99);
		if (pick < 30) begin
			it.opcode = OP_TICK;
		end else if (pick < 52) begin
			it.opcode = OP_SET;
			it.az     = 17'(target_az());
			it.el     = 17'(target_el());
		end else if (pick < 80) begin
			it.opcode = OP_FEEDBACK;
			it.az     = 17'(sensor_az());
			it.el     = 17'(sensor_el());
		end else if (pick < 86) begin
			it.opcode = OP_STOP;
		end else if (pick < 92) begin
			it.opcode = OP_ZERO;
		end else if (pick < 97) begin
			it.opcode = OP_MAINT;
			case ($urandom_range(5))
				0: it.duration = 16'd0;
				1: it.duration = 16'hFFFF;
				2: it.duration = 16'($urandom);
				default: it.duration = 16'($urandom_range(1, 30));
			endcase
		end else begin
			it.opcode = opcode_t'(OP_UNUSED);
		end
		return it;
	endfunction

	// offer one item, hold it while stalled, note it once taken
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		opcode          <= it.opcode;
		azimuth_valid   <= it.az_valid;
		elevation_valid <= it.el_valid;
		azimuth_cdeg    <= it.az;
		elevation_cdeg  <= it.el;
		duration_ms     <= it.duration;
		@(negedge clk);
		while (in_stall) @(negedge clk);
		sb.take_event(it);
		@(posedge clk);
	endtask

	// drop valid and wait for every expected result to arrive
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.status_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic write_config(input bit ext, input int tmo, input int db);
		write_reg(REG_EXT, {15'd0, ext});
		write_reg(REG_TIMEOUT, 16'(tmo));
		write_reg(REG_DEADBAND, 16'(db));
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// random phase with occasional tick bursts; optionally latch a fault late
	task automatic run_phase(input int n, input bit with_fault);
		int    k;
		int    burst;
		bit    fault_sent;
		item_t it;
		k          = 0;
		fault_sent = 1'b0;
		while (k < n) begin
			if (with_fault && !fault_sent && k >= (n * 3) / 4) begin
				it        = random_item();
				it.opcode = OP_FAULT;
				send_item(it);
				fault_sent = 1'b1;
				k++;
			end else if ($urandom_range(99) < 6) begin
				burst = $urandom_range(1, 12);
				repeat (burst) begin
					it        = random_item();
					it.opcode = OP_TICK;
					send_item(it);
				end
				k += burst;
			end else begin
				send_item(random_item());
				k++;
			end
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// simulator mode at reset settings: range checks, zero, maintenance, raw checks, unused opcode, stop
		send_item(mk(OP_TICK, 0, 0, 0, 0, 0));
		send_item(mk(OP_SET, 1, 1, 35900, 18000, 0));
		send_item(mk(OP_SET, 1, 0, 35901, 0, 0));
		send_item(mk(OP_SET, 1, 1, -1, 100, 0));
		send_item(mk(OP_SET, 0, 1, -36000, -1, 0));
		send_item(mk(OP_SET, 0, 1, 0, 18001, 0));
		send_item(mk(OP_SET, 1, 1, 0, 0, 0));
		send_item(mk(OP_ZERO, 1, 1, -65536, 65535, 65535));
		send_item(mk(OP_MAINT, 0, 0, 0, 0, 0));
		send_item(mk(OP_SET, 1, 1, 100, 100, 0));
		send_item(mk(OP_ZERO, 0, 0, 0, 0, 0));
		send_item(mk(OP_FEEDBACK, 0, 0, 35999, -18000, 0));
		send_item(mk(OP_FEEDBACK, 0, 0, 36000, 0, 0));
		send_item(mk(OP_FEEDBACK, 0, 0, -1, 18001, 0));
		send_item(mk(OP_FEEDBACK, 1, 1, 35999, 18000, 0));
		send_item(mk(opcode_t'(OP_UNUSED), 1, 1, 500, 500, 7));
		send_item(mk(OP_STOP, 0, 0, 0, 0, 0));
		drain();

		// external mode: missing feedback, wrap, moving, stale, zero offsets
		write_config(1'b1, 2, 0);
		send_item(mk(OP_SET, 1, 1, 100, 100, 0));
		send_item(mk(OP_ZERO, 0, 0, 0, 0, 0));
		send_item(mk(OP_FEEDBACK, 0, 0, 0, 0, 0));
		send_item(mk(OP_SET, 1, 1, 35000, 50, 0));
		send_item(mk(OP_ZERO, 0, 0, 0, 0, 0));
		repeat (3) send_item(mk(OP_TICK, 0, 0, 0, 0, 0));
		send_item(mk(OP_SET, 1, 1, 200, 200, 0));
		send_item(mk(OP_FEEDBACK, 0, 0, 35000, 50, 0));
		send_item(mk(OP_STOP, 0, 0, 0, 0, 0));
		send_item(mk(OP_ZERO, 0, 0, 0, 0, 0));
		drain();

		// sender idles lightly, receiver stalls heavily
		write_config(1'b0, 1000, 50);
		run_phase(105, 1'b0);
		write_config(1'b1, 5, 0);
		run_phase(105, 1'b0);
		write_config(1'b1, 65535, 1000);
		run_phase(105, 1'b0);

		// sender idles heavily, receiver stalls lightly
		send_idle_pct  = 70;
		recv_stall_pct = 31;
		write_config(1'b1, 0, 50);
		run_phase(105, 1'b0);
		write_config(1'b0, $urandom_range(1, 65535), 1000);
		run_phase(105, 1'b0);
		write_config(1'b1, 1, $urandom_range(1000));
		run_phase(105, 1'b0);

		// full rate on both sides; the fault latch comes last since it holds
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_config(1'b1, 20, 25);
		run_phase(105, 1'b0);
		write_config(1'b1, 8, $urandom_range(1000));
		run_phase(105, 1'b0);
		write_config(1'b1, 3, 50);
		run_phase(105, 1'b1);

		if (sb.fail_count == 0 && sb.status_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
